// File: sv/dnts_pkg.sv
// ---------------------------------------------------------------------------
// dnts_pkg
// Shared types and constants of the decimal number token scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package dnts_pkg;

  // Positions and the fraction digit count saturate here
  localparam int unsigned TOKEN_LEN_MAX = 4096;
  localparam int unsigned POS_W         = $clog2(TOKEN_LEN_MAX + 1);

  localparam int unsigned ACC_W       = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_DIGIT,
    CLS_MINUS,
    CLS_PLUS,
    CLS_DOT,
    CLS_EXP,
    CLS_OTHER
  } char_cls_e;

  typedef struct packed {
    char_cls_e  cls;
    logic [3:0] digit;
    logic       is_last;
  } item_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_AFTER_SIGN,
    PH_AFTER_ZERO,
    PH_INT,
    PH_AFTER_DOT,
    PH_FRAC,
    PH_AFTER_E,
    PH_AFTER_ESIGN,
    PH_EXP
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_END,
    ERR_ZERO,
    ERR_DIGIT,
    ERR_LARGE,
    ERR_SYMBOL
  } err_e;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_FLOAT,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_WHOLE,
    ACC_FRAC,
    ACC_EXP
  } acc_sel_e;

  // What the current character does to the datapath
  typedef struct packed {
    acc_sel_e acc_sel;
    err_e     err;
    logic     set_sign;
    logic     set_exp_sign;
  } action_t;

  typedef struct packed {
    kind_e             kind;
    logic [ACC_W-1:0]  int_value;
    logic              is_negative;
    logic [ACC_W-1:0]  whole_digits;
    logic [ACC_W-1:0]  fraction_digits;
    logic [POS_W-1:0]  fraction_count;
    logic              exp_is_negative;
    logic [ACC_W-1:0]  exp_magnitude;
    err_e              error_code;
    logic [POS_W-1:0]  error_position;
  } result_t;

endpackage

`default_nettype wire

// File: sv/dnts_front.sv
// ---------------------------------------------------------------------------
// dnts_front
// Character classifier: turns an ASCII code into a character class and
// digit value for the scan engine.
// ---------------------------------------------------------------------------
`default_nettype none

module dnts_front import dnts_pkg::*; (
  input  var logic [7:0] char_code_i,
  input  var logic       is_last_i,
  output item_t          item_o
);

  always_comb begin
    item_o.digit   = char_code_i[3:0];
    item_o.is_last = is_last_i;
    if (char_code_i == CH_ZERO) begin
      item_o.cls = CLS_ZERO;
    end else if (char_code_i > CH_ZERO && char_code_i <= CH_NINE) begin
      item_o.cls = CLS_DIGIT;
    end else if (char_code_i == CH_MINUS) begin
      item_o.cls = CLS_MINUS;
    end else if (char_code_i == CH_PLUS) begin
      item_o.cls = CLS_PLUS;
    end else if (char_code_i == CH_DOT) begin
      item_o.cls = CLS_DOT;
    end else if (char_code_i == CH_LOW_E || char_code_i == CH_UP_E) begin
      item_o.cls = CLS_EXP;
    end else begin
      item_o.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

// File: sv/dnts_queue.sv
// ---------------------------------------------------------------------------
// dnts_queue
// Short queue of classified characters between classifier and scan engine.
// ---------------------------------------------------------------------------
`default_nettype none

module dnts_queue import dnts_pkg::*; (
  input  var logic  clk_i,
  input  var logic  rst_ni,
  input  var logic  push_i,
  input  item_t     item_i,
  output logic      full_o,
  output logic      valid_o,
  output item_t     item_o,
  input  var logic  pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_moves_rptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop without matching count drop");

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |=> valid_o)
    else $error("queue empty right after push");

endmodule

`default_nettype wire

// File: sv/dnts_back.sv
// ---------------------------------------------------------------------------
// dnts_back
// Scan engine: phase machine, shared times-ten accumulator unit, first-error
// capture and the one-entry result register.
// ---------------------------------------------------------------------------
`default_nettype none

module dnts_back import dnts_pkg::*; (
  input  var logic  clk_i,
  input  var logic  rst_ni,
  input  var logic  item_valid_i,
  input  item_t     item_i,
  output logic      item_pop_o,
  output result_t   result_o,
  output logic      empty,
  input  var logic  pop
);

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(TOKEN_LEN_MAX);

  phase_e           phase_q, phase_d, phase_step;
  logic             sign_q, sign_d;
  logic [ACC_W-1:0] whole_q, whole_d;
  logic [ACC_W-1:0] frac_q, frac_d;
  logic [POS_W-1:0] frac_cnt_q, frac_cnt_d;
  logic             exp_sign_q, exp_sign_d;
  logic [ACC_W-1:0] exp_q, exp_d;
  logic             float_q, float_d;
  logic [POS_W-1:0] char_idx_q, length;
  err_e             held_q, err_scan, err_fin;
  logic [POS_W-1:0] held_pos_q, pos_scan, pos_fin;

  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;

  action_t          act;
  logic             is_dig, scan_en, take;
  logic [ACC_W-1:0] acc_cur;
  logic [ACC_W+3:0] acc_ext, acc_next;
  logic             acc_ovf;

  assign is_dig     = (item_i.cls == CLS_ZERO) || (item_i.cls == CLS_DIGIT);
  assign scan_en    = (held_q == ERR_NONE);
  assign take       = item_valid_i && (!item_i.is_last || !out_valid_q || pop);
  assign item_pop_o = take;
  assign empty      = !out_valid_q;
  assign result_o   = res_q;

  // Datapath action per phase and character class
  always_comb begin
    act = '{acc_sel: ACC_NONE, err: ERR_NONE, set_sign: 1'b0, set_exp_sign: 1'b0};
    case (phase_q)
      PH_START, PH_AFTER_SIGN: begin
        if (phase_q == PH_START && item_i.cls inside {CLS_MINUS, CLS_PLUS}) begin
          act.set_sign = 1'b1;
        end else if (item_i.cls == CLS_DIGIT) begin
          act.acc_sel = ACC_WHOLE;
        end else if (item_i.cls != CLS_ZERO) begin
          act.err = ERR_DIGIT;
        end
      end
      PH_AFTER_ZERO: begin
        if (!(item_i.cls inside {CLS_DOT, CLS_EXP})) begin
          act.err = ERR_ZERO;
        end
      end
      PH_INT: begin
        if (is_dig) begin
          act.acc_sel = ACC_WHOLE;
        end else if (!(item_i.cls inside {CLS_DOT, CLS_EXP})) begin
          act.err = ERR_SYMBOL;
        end
      end
      PH_AFTER_DOT, PH_FRAC: begin
        if (is_dig) begin
          act.acc_sel = ACC_FRAC;
        end else if (phase_q == PH_AFTER_DOT) begin
          act.err = ERR_DIGIT;
        end else if (item_i.cls != CLS_EXP) begin
          act.err = ERR_SYMBOL;
        end
      end
      PH_AFTER_E, PH_AFTER_ESIGN, PH_EXP: begin
        if (is_dig) begin
          act.acc_sel = ACC_EXP;
        end else if (phase_q == PH_AFTER_E && item_i.cls inside {CLS_MINUS, CLS_PLUS}) begin
          act.set_exp_sign = 1'b1;
        end else if (phase_q == PH_EXP) begin
          act.err = ERR_SYMBOL;
        end else begin
          act.err = ERR_DIGIT;
        end
      end
      default: begin
        act.err = ERR_SYMBOL;
      end
    endcase
  end

  // Next phase
  always_comb begin
    phase_step = phase_q;
    case (phase_q)
      PH_START, PH_AFTER_SIGN: begin
        if (phase_q == PH_START && item_i.cls inside {CLS_MINUS, CLS_PLUS}) begin
          phase_step = PH_AFTER_SIGN;
        end else if (item_i.cls == CLS_ZERO) begin
          phase_step = PH_AFTER_ZERO;
        end else if (item_i.cls == CLS_DIGIT) begin
          phase_step = PH_INT;
        end
      end
      PH_AFTER_ZERO, PH_INT: begin
        if (item_i.cls == CLS_DOT) begin
          phase_step = PH_AFTER_DOT;
        end else if (item_i.cls == CLS_EXP) begin
          phase_step = PH_AFTER_E;
        end
      end
      PH_AFTER_DOT, PH_FRAC: begin
        if (is_dig) begin
          phase_step = PH_FRAC;
        end else if (phase_q == PH_FRAC && item_i.cls == CLS_EXP) begin
          phase_step = PH_AFTER_E;
        end
      end
      PH_AFTER_E, PH_AFTER_ESIGN, PH_EXP: begin
        if (is_dig) begin
          phase_step = PH_EXP;
        end else if (phase_q == PH_AFTER_E && item_i.cls inside {CLS_MINUS, CLS_PLUS}) begin
          phase_step = PH_AFTER_ESIGN;
        end
      end
      default: begin
        phase_step = phase_q;
      end
    endcase
  end

  // Shared acc*10 + d; overflow when anything lands above bit 63
  always_comb begin
    case (act.acc_sel)
      ACC_WHOLE: acc_cur = whole_q;
      ACC_FRAC:  acc_cur = frac_q;
      ACC_EXP:   acc_cur = exp_q;
      default:   acc_cur = '0;
    endcase
    acc_ext  = {4'b0, acc_cur};
    acc_next = (acc_ext << 3) + (acc_ext << 1) + {{ACC_W{1'b0}}, item_i.digit};
    acc_ovf  = |acc_next[ACC_W+3:ACC_W];
  end

  // State update and first-error capture
  always_comb begin
    phase_d    = phase_q;
    sign_d     = sign_q;
    whole_d    = whole_q;
    frac_d     = frac_q;
    frac_cnt_d = frac_cnt_q;
    exp_sign_d = exp_sign_q;
    exp_d      = exp_q;
    float_d    = float_q;
    err_scan   = held_q;
    pos_scan   = held_pos_q;
    if (scan_en) begin
      phase_d = phase_step;
      if (act.set_sign) begin
        sign_d = (item_i.cls == CLS_MINUS);
      end
      if (act.set_exp_sign) begin
        exp_sign_d = (item_i.cls == CLS_MINUS);
      end
      case (act.acc_sel)
        ACC_WHOLE: begin
          if (!acc_ovf) whole_d = acc_next[ACC_W-1:0];
        end
        ACC_FRAC: begin
          if (!acc_ovf) frac_d = acc_next[ACC_W-1:0];
          if (frac_cnt_q < POS_MAX) frac_cnt_d = frac_cnt_q + POS_W'(1);
          float_d = 1'b1;
        end
        ACC_EXP: begin
          if (!acc_ovf) exp_d = acc_next[ACC_W-1:0];
          float_d = 1'b1;
        end
        default: ;
      endcase
      if (act.err != ERR_NONE) begin
        err_scan = act.err;
        pos_scan = char_idx_q;
      end else if (act.acc_sel != ACC_NONE && acc_ovf) begin
        err_scan = ERR_LARGE;
        pos_scan = char_idx_q;
      end
    end
  end

  assign length = (char_idx_q < POS_MAX) ? char_idx_q + POS_W'(1) : char_idx_q;

  // End-of-token checks and result formation
  always_comb begin
    err_fin = err_scan;
    pos_fin = pos_scan;
    if (err_scan == ERR_NONE) begin
      if (phase_d inside {PH_START, PH_AFTER_SIGN, PH_AFTER_DOT, PH_AFTER_E,
                          PH_AFTER_ESIGN}) begin
        err_fin = ERR_END;
        pos_fin = length;
      end else if (!float_d && whole_d[ACC_W-1] && (!sign_d || |whole_d[ACC_W-2:0])) begin
        err_fin = ERR_LARGE;
        pos_fin = length;
      end
    end

    res_d = '0;
    if (err_fin != ERR_NONE) begin
      res_d.kind           = KIND_ERROR;
      res_d.error_code     = err_fin;
      res_d.error_position = pos_fin;
    end else if (float_d) begin
      res_d.kind            = KIND_FLOAT;
      res_d.is_negative     = sign_d;
      res_d.whole_digits    = whole_d;
      res_d.fraction_digits = frac_d;
      res_d.fraction_count  = frac_cnt_d;
      res_d.exp_is_negative = exp_sign_d;
      res_d.exp_magnitude   = exp_d;
    end else begin
      res_d.kind        = KIND_INT;
      res_d.int_value   = sign_d ? ACC_W'(0) - whole_d : whole_d;
      res_d.is_negative = sign_d;
    end

    out_valid_d = out_valid_q;
    if (take && item_i.is_last) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      sign_q      <= 1'b0;
      whole_q     <= '0;
      frac_q      <= '0;
      frac_cnt_q  <= '0;
      exp_sign_q  <= 1'b0;
      exp_q       <= '0;
      float_q     <= 1'b0;
      char_idx_q  <= '0;
      held_q      <= ERR_NONE;
      held_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take && item_i.is_last) begin
        phase_q    <= PH_START;
        sign_q     <= 1'b0;
        whole_q    <= '0;
        frac_q     <= '0;
        frac_cnt_q <= '0;
        exp_sign_q <= 1'b0;
        exp_q      <= '0;
        float_q    <= 1'b0;
        char_idx_q <= '0;
        held_q     <= ERR_NONE;
        held_pos_q <= '0;
      end else if (take) begin
        phase_q    <= phase_d;
        sign_q     <= sign_d;
        whole_q    <= whole_d;
        frac_q     <= frac_d;
        frac_cnt_q <= frac_cnt_d;
        exp_sign_q <= exp_sign_d;
        exp_q      <= exp_d;
        float_q    <= float_d;
        char_idx_q <= length;
        held_q     <= err_scan;
        held_pos_q <= pos_scan;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.is_last) begin
      res_q <= res_d;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_i.is_last |=> phase_q == PH_START && held_q == ERR_NONE
                               && char_idx_q == '0)
    else $error("scan state not cleared after last transfer");

  a_idx_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_idx_q <= POS_MAX)
    else $error("character index past saturation");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != ERR_NONE && take && !item_i.is_last |=> $stable(held_q) && $stable(held_pos_q))
    else $error("held error changed mid-token");

  a_kind_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_q.kind == KIND_ERROR) == (res_q.error_code != ERR_NONE)))
    else $error("result kind and error code disagree");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |-> !(take && item_i.is_last))
    else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

// File: sv/decimal_number_token_scanner.sv
// ---------------------------------------------------------------------------
// decimal_number_token_scanner
// Scans a decimal number token one character at a time and returns its
// integer value, float components or the first error.
// ---------------------------------------------------------------------------
// One character is taken per clock cycle while the queue is not full, with
// no gaps between tokens. A classifier decodes each character on entry into a
// two-entry queue; the scan engine retires one queued character per cycle
// through a single shared times-ten-plus-digit unit, so the sustained rate is
// one character per cycle while results are popped. When the engine takes a
// token's last character from the queue, the result is registered in a
// one-entry result register; while it waits, the engine keeps consuming
// characters of the next token and stalls only on that token's last character.
`default_nettype none

module decimal_number_token_scanner import dnts_pkg::*; (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var logic                push,
  output logic                    full,
  input  var logic [7:0]          char_code_i,
  input  var logic                is_last_i,
  output logic                    empty,
  input  var logic                pop,
  output logic [1:0]              kind_o,
  output logic signed [ACC_W-1:0] int_value_o,
  output logic                    is_negative_o,
  output logic [ACC_W-1:0]        whole_digits_o,
  output logic [ACC_W-1:0]        fraction_digits_o,
  output logic [POS_W-1:0]        fraction_count_o,
  output logic                    exp_is_negative_o,
  output logic [ACC_W-1:0]        exp_magnitude_o,
  output logic [2:0]              error_code_o,
  output logic [POS_W-1:0]        error_position_o
);

  item_t   cls_item, q_item;
  logic    q_valid, q_pop;
  result_t res;

  dnts_front u_front (
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .item_o      (cls_item)
  );

  dnts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (cls_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  dnts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .result_o     (res),
    .empty        (empty),
    .pop          (pop)
  );

  assign kind_o            = res.kind;
  assign int_value_o       = res.int_value;
  assign is_negative_o     = res.is_negative;
  assign whole_digits_o    = res.whole_digits;
  assign fraction_digits_o = res.fraction_digits;
  assign fraction_count_o  = res.fraction_count;
  assign exp_is_negative_o = res.exp_is_negative;
  assign exp_magnitude_o   = res.exp_magnitude;
  assign error_code_o      = res.error_code;
  assign error_position_o  = res.error_position;

endmodule

`default_nettype wire

// File: sim/decimal_number_token_scanner_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_number_token_scanner_tb
// Feeds number tokens one character per transfer: directed tokens first,
// then random well-formed and broken tokens. Most directed results are
// checked against the table, the rest against the bench's scan model.
// ---------------------------------------------------------------------------

module decimal_number_token_scanner_tb;
  import dnts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_CHARS = 880;

  typedef logic [7:0] char_q_t[$];

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         typed;
    result_t    want;
  } feed_item_t;

  typedef struct {
    string       text;
    bit          typed;
    kind_e       kind;
    logic [63:0] ival;
    bit          neg;
    err_e        ec;
    int          epos;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    push;
  logic                    full;
  logic [7:0]              char_code_i;
  logic                    is_last_i;
  logic                    empty;
  logic                    pop;
  logic [1:0]              kind_o;
  logic signed [ACC_W-1:0] int_value_o;
  logic                    is_negative_o;
  logic [ACC_W-1:0]        whole_digits_o;
  logic [ACC_W-1:0]        fraction_digits_o;
  logic [POS_W-1:0]        fraction_count_o;
  logic                    exp_is_negative_o;
  logic [ACC_W-1:0]        exp_magnitude_o;
  logic [2:0]              error_code_o;
  logic [POS_W-1:0]        error_position_o;

  feed_item_t  char_feed[$];
  result_t     expected_numbers[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  logic        quiet;

  // scan model state
  phase_e           sc_phase;
  logic             sc_neg;
  logic [ACC_W-1:0] sc_whole;
  logic [ACC_W-1:0] sc_frac;
  int unsigned      sc_frac_len;
  logic             sc_exp_neg;
  logic [ACC_W-1:0] sc_exp;
  logic             sc_float;
  int unsigned      sc_pos;
  err_e             sc_err;
  int unsigned      sc_err_pos;

  dir_row_t dir_rows [26] = '{
    '{"0", 1, KIND_INT, 64'd0, 0, ERR_NONE, 0},
    '{"-0", 1, KIND_INT, 64'd0, 1, ERR_NONE, 0},
    '{"+7", 1, KIND_INT, 64'd7, 0, ERR_NONE, 0},
    '{"9223372036854775807", 1, KIND_INT, 64'h7FFF_FFFF_FFFF_FFFF, 0, ERR_NONE, 0},
    '{"-9223372036854775808", 1, KIND_INT, 64'h8000_0000_0000_0000, 1, ERR_NONE, 0},
    '{"9223372036854775808", 1, KIND_ERROR, 64'd0, 0, ERR_LARGE, 19},
    '{"18446744073709551616", 1, KIND_ERROR, 64'd0, 0, ERR_LARGE, 19},
    '{"18446744073709551615", 1, KIND_ERROR, 64'd0, 0, ERR_LARGE, 20},
    '{"-", 1, KIND_ERROR, 64'd0, 0, ERR_END, 1},
    '{"1.", 1, KIND_ERROR, 64'd0, 0, ERR_END, 2},
    '{"1e", 1, KIND_ERROR, 64'd0, 0, ERR_END, 2},
    '{"1e+", 1, KIND_ERROR, 64'd0, 0, ERR_END, 3},
    '{"01", 1, KIND_ERROR, 64'd0, 0, ERR_ZERO, 1},
    '{"x", 1, KIND_ERROR, 64'd0, 0, ERR_DIGIT, 0},
    '{"-a", 1, KIND_ERROR, 64'd0, 0, ERR_DIGIT, 1},
    '{"1.x", 1, KIND_ERROR, 64'd0, 0, ERR_DIGIT, 2},
    '{"1e.", 1, KIND_ERROR, 64'd0, 0, ERR_DIGIT, 2},
    '{"12a", 1, KIND_ERROR, 64'd0, 0, ERR_SYMBOL, 2},
    '{"1.5-", 1, KIND_ERROR, 64'd0, 0, ERR_SYMBOL, 3},
    '{"1e5x", 1, KIND_ERROR, 64'd0, 0, ERR_SYMBOL, 3},
    '{"12x9.5", 1, KIND_ERROR, 64'd0, 0, ERR_SYMBOL, 2},
    '{"1e99999999999999999999", 1, KIND_ERROR, 64'd0, 0, ERR_LARGE, 21},
    '{"1.18446744073709551616", 1, KIND_ERROR, 64'd0, 0, ERR_LARGE, 21},
    '{"-3.14E-2", 0, KIND_FLOAT, 64'd0, 0, ERR_NONE, 0},
    '{"0.000123e+045", 0, KIND_FLOAT, 64'd0, 0, ERR_NONE, 0},
    '{"-0.5e+0\377", 0, KIND_FLOAT, 64'd0, 0, ERR_NONE, 0}
  };

  decimal_number_token_scanner dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .char_code_i      (char_code_i),
    .is_last_i        (is_last_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind_o),
    .int_value_o      (int_value_o),
    .is_negative_o    (is_negative_o),
    .whole_digits_o   (whole_digits_o),
    .fraction_digits_o(fraction_digits_o),
    .fraction_count_o (fraction_count_o),
    .exp_is_negative_o(exp_is_negative_o),
    .exp_magnitude_o  (exp_magnitude_o),
    .error_code_o     (error_code_o),
    .error_position_o (error_position_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic clear_scan();
    sc_phase    = PH_START;
    sc_neg      = 1'b0;
    sc_whole    = '0;
    sc_frac     = '0;
    sc_frac_len = 0;
    sc_exp_neg  = 1'b0;
    sc_exp      = '0;
    sc_float    = 1'b0;
    sc_pos      = 0;
    sc_err      = ERR_NONE;
    sc_err_pos  = 0;
  endtask

  task automatic raise(input err_e code, input int unsigned where);
    if (sc_err == ERR_NONE) begin
      sc_err     = code;
      sc_err_pos = where;
    end
  endtask

  // acc = acc * 10 + digit, flagged as too large on 64-bit overflow
  task automatic take_digit(inout logic [ACC_W-1:0] acc, input logic [7:0] c);
    logic [ACC_W-1:0] d;
    d = ACC_W'(c - CH_ZERO);
    if (acc > ({ACC_W{1'b1}} - d) / 10) raise(ERR_LARGE, sc_pos);
    else acc = acc * 10 + d;
  endtask

  task automatic scan_token_char(input logic [7:0] c, input logic last,
                                 output bit has_res, output result_t r);
    bit dig, ee, sgn;
    dig = c >= CH_ZERO && c <= CH_NINE;
    ee  = c == CH_LOW_E || c == CH_UP_E;
    sgn = c == CH_MINUS || c == CH_PLUS;
    has_res = 1'b0;
    r = '0;
    if (sc_err == ERR_NONE) begin
      case (sc_phase)
        PH_START, PH_AFTER_SIGN: begin
          if (sc_phase == PH_START && sgn) begin
            sc_neg   = c == CH_MINUS;
            sc_phase = PH_AFTER_SIGN;
          end else if (c == CH_ZERO) begin
            sc_phase = PH_AFTER_ZERO;
          end else if (dig) begin
            take_digit(sc_whole, c);
            sc_phase = PH_INT;
          end else raise(ERR_DIGIT, sc_pos);
        end
        PH_AFTER_ZERO, PH_INT: begin
          if (c == CH_DOT) sc_phase = PH_AFTER_DOT;
          else if (ee) sc_phase = PH_AFTER_E;
          else if (sc_phase == PH_AFTER_ZERO) raise(ERR_ZERO, sc_pos);
          else if (dig) take_digit(sc_whole, c);
          else raise(ERR_SYMBOL, sc_pos);
        end
        PH_AFTER_DOT, PH_FRAC: begin
          if (dig) begin
            take_digit(sc_frac, c);
            if (sc_frac_len < TOKEN_LEN_MAX) sc_frac_len++;
            sc_float = 1'b1;
            sc_phase = PH_FRAC;
          end else if (sc_phase == PH_AFTER_DOT) raise(ERR_DIGIT, sc_pos);
          else if (ee) sc_phase = PH_AFTER_E;
          else raise(ERR_SYMBOL, sc_pos);
        end
        PH_AFTER_E, PH_AFTER_ESIGN, PH_EXP: begin
          if (dig) begin
            take_digit(sc_exp, c);
            sc_float = 1'b1;
            sc_phase = PH_EXP;
          end else if (sc_phase == PH_AFTER_E && sgn) begin
            sc_exp_neg = c == CH_MINUS;
            sc_phase   = PH_AFTER_ESIGN;
          end else if (sc_phase == PH_EXP) raise(ERR_SYMBOL, sc_pos);
          else raise(ERR_DIGIT, sc_pos);
        end
        default: raise(ERR_SYMBOL, sc_pos);
      endcase
    end
    if (sc_pos < TOKEN_LEN_MAX) sc_pos++;
    if (last) begin
      if (sc_err == ERR_NONE) begin
        if (sc_phase inside {PH_START, PH_AFTER_SIGN, PH_AFTER_DOT, PH_AFTER_E,
                             PH_AFTER_ESIGN})
          raise(ERR_END, sc_pos);
        else if (!sc_float &&
                 sc_whole > ({1'b0, {(ACC_W-1){1'b1}}} + ACC_W'(sc_neg)))
          raise(ERR_LARGE, sc_pos);
      end
      has_res = 1'b1;
      if (sc_err != ERR_NONE) begin
        r.kind           = KIND_ERROR;
        r.error_code     = sc_err;
        r.error_position = POS_W'(sc_err_pos);
      end else if (sc_float) begin
        r.kind            = KIND_FLOAT;
        r.is_negative     = sc_neg;
        r.whole_digits    = sc_whole;
        r.fraction_digits = sc_frac;
        r.fraction_count  = POS_W'(sc_frac_len);
        r.exp_is_negative = sc_exp_neg;
        r.exp_magnitude   = sc_exp;
      end else begin
        r.kind        = KIND_INT;
        r.int_value   = sc_neg ? -sc_whole : sc_whole;
        r.is_negative = sc_neg;
      end
      clear_scan();
    end
  endtask

  task automatic check_field(input string fname, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h actual %0h", fname, want, got);
    end
  endtask

  task automatic push_token(input char_q_t t, input bit typed, input result_t want);
    feed_item_t it;
    foreach (t[i]) begin
      it.ch    = t[i];
      it.last  = i == t.size() - 1;
      it.typed = typed && it.last;
      it.want  = want;
      char_feed.push_back(it);
    end
  endtask

  // mostly short digit runs, now and then long enough to reach overflow
  function automatic int digit_span();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(17, 19);
  endfunction

  function automatic char_q_t rand_digits(input int n);
    char_q_t t;
    repeat (n) t.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    return t;
  endfunction

  function automatic char_q_t make_token();
    char_q_t t;
    int      roll, k;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
      return t;
    end
    if ($urandom_range(0, 9) < 3) t.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    if ($urandom_range(0, 6) == 0) t.push_back(CH_ZERO);
    else begin
      t.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
      t = {t, rand_digits(digit_span())};
    end
    if ($urandom_range(0, 1) == 1) begin
      t.push_back(CH_DOT);
      t = {t, rand_digits(digit_span() + 1)};
    end
    if ($urandom_range(0, 4) < 2) begin
      t.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
      case ($urandom_range(0, 2))
        0: t.push_back(CH_MINUS);
        1: t.push_back(CH_PLUS);
        default: ;
      endcase
      t = {t, rand_digits(digit_span() + 1)};
    end
    // broken sequences: overwrite, cut short or splice in a symbol
    if (roll >= 78) begin
      k = $urandom_range(0, t.size() - 1);
      case ($urandom_range(0, 2))
        0: t[k] = 8'($urandom_range(0, 255));
        1: while (t.size() > k + 1) void'(t.pop_back());
        default: begin
          case ($urandom_range(0, 5))
            0: t.insert(k, CH_DOT);
            1: t.insert(k, CH_LOW_E);
            2: t.insert(k, CH_MINUS);
            3: t.insert(k, CH_PLUS);
            4: t.insert(k, CH_ZERO);
            default: t.insert(k, 8'($urandom_range(0, 255)));
          endcase
        end
      endcase
    end
    return t;
  endfunction

  assign quiet = cycle_count >= 800 && cycle_count < 1300;

  // drive at the falling edge
  always @(negedge clk_i) begin
    if (char_feed.size() != 0 && (quiet || $urandom_range(0, 99) >= 22)) begin
      push        <= 1'b1;
      char_code_i <= char_feed[0].ch;
      is_last_i   <= char_feed[0].last;
    end else begin
      push <= 1'b0;
    end
    pop <= quiet || $urandom_range(0, 99) >= 22;
  end

  // sample at the rising edge
  always @(posedge clk_i) begin
    bit      got_res;
    result_t predicted;
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
    if (rst_ni) begin
      if (push && !full) begin
        scan_token_char(char_feed[0].ch, char_feed[0].last, got_res, predicted);
        if (got_res)
          expected_numbers.push_back(char_feed[0].typed ? char_feed[0].want : predicted);
        void'(char_feed.pop_front());
      end
      if (pop && !empty) begin
        if (expected_numbers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result transfer with nothing expected");
        end else begin
          want = expected_numbers.pop_front();
          check_field("kind", kind_o, want.kind);
          check_field("int_value", int_value_o, want.int_value);
          check_field("is_negative", is_negative_o, want.is_negative);
          check_field("whole_digits", whole_digits_o, want.whole_digits);
          check_field("fraction_digits", fraction_digits_o, want.fraction_digits);
          check_field("fraction_count", fraction_count_o, want.fraction_count);
          check_field("exp_is_negative", exp_is_negative_o, want.exp_is_negative);
          check_field("exp_magnitude", exp_magnitude_o, want.exp_magnitude);
          check_field("error_code", error_code_o, want.error_code);
          check_field("error_position", error_position_o, want.error_position);
        end
      end
    end
  end

  initial begin
    char_q_t     t;
    result_t     want;
    int unsigned random_chars;
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    char_code_i  = '0;
    is_last_i    = 1'b0;
    mismatches   = 0;
    cycle_count  = 0;
    random_chars = 0;
    clear_scan();

    foreach (dir_rows[r]) begin
      t.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) t.push_back(dir_rows[r].text[i]);
      want      = '0;
      want.kind = dir_rows[r].kind;
      if (dir_rows[r].kind == KIND_INT) begin
        want.int_value   = dir_rows[r].ival;
        want.is_negative = dir_rows[r].neg;
      end else if (dir_rows[r].kind == KIND_ERROR) begin
        want.error_code     = dir_rows[r].ec;
        want.error_position = POS_W'(dir_rows[r].epos);
      end
      push_token(t, dir_rows[r].typed, want);
    end

    want = '0;
    while (random_chars < RANDOM_CHARS) begin
      t = make_token();
      random_chars += t.size();
      push_token(t, 1'b0, want);
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_feed.size() != 0 || expected_numbers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/dnts_pkg.sv
sv/dnts_front.sv
sv/dnts_queue.sv
sv/dnts_back.sv
sv/decimal_number_token_scanner.sv
sim/decimal_number_token_scanner_tb.sv
